[design/wrsi_pkg.sv]
`default_nettype none
package wrsi_pkg;

  localparam int unsigned PRICE_BITS = 32;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned AVG_BITS   = PRICE_BITS + FRAC_BITS;
  localparam int unsigned PER_BITS   = 8;
  localparam int unsigned RSI_BITS   = 15;
  localparam int unsigned PROD_W     = AVG_BITS + PER_BITS;

  // divider sizes: dividend holds 25600 * avg, divisor holds gain + loss
  localparam int unsigned DVD_W    = AVG_BITS + RSI_BITS;
  localparam int unsigned DVS_W    = AVG_BITS + 1;
  localparam int unsigned LONG_IT  = AVG_BITS + PER_BITS + 1;
  localparam int unsigned SHORT_IT = RSI_BITS;
  localparam int unsigned CNT_W    = $clog2(LONG_IT + 1);

  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  localparam logic [PER_BITS-1:0] PERIOD_RESET = PER_BITS'(14);
  localparam logic [PER_BITS-1:0] PERIOD_MIN   = PER_BITS'(2);
  localparam logic [PER_BITS-1:0] WARM_MAX     = '1;

  typedef enum logic [ADDR_W-3:0] {
    REG_PERIOD = 1'b0
  } reg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MOVE,
    S_GAIN,
    S_GAIN_WAIT,
    S_LOSS,
    S_LOSS_WAIT,
    S_RSI,
    S_RSI_WAIT,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic             start;
    logic             short_op;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quot;
  } div_rsp_t;

  // 25600 = 2^14 + 2^13 + 2^10
  function automatic logic [DVD_W-1:0] rsi_dividend(input logic [AVG_BITS-1:0] g);
    logic [DVD_W-1:0] x;
    x = DVD_W'(g);
    return (x << 14) + (x << 13) + (x << 10);
  endfunction

endpackage
`default_nettype wire

[design/wrsi_div.sv]
`default_nettype none
module wrsi_div (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wrsi_pkg::div_req_t   req_i,
  output wrsi_pkg::div_rsp_t   rsp_o
);

  logic                         busy_q;
  logic                         done_q;
  logic [wrsi_pkg::CNT_W-1:0]   cnt_q;
  logic [wrsi_pkg::DVS_W-1:0]   rem_q;
  logic [wrsi_pkg::DVS_W-1:0]   dvs_q;
  logic [wrsi_pkg::DVD_W-1:0]   quo_q;
  logic [wrsi_pkg::DVS_W:0]     trial;
  logic [wrsi_pkg::DVS_W:0]     diff;
  logic                         fits;

  assign trial = {rem_q, quo_q[wrsi_pkg::DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.short_op ? wrsi_pkg::CNT_W'(wrsi_pkg::SHORT_IT)
                                 : wrsi_pkg::CNT_W'(wrsi_pkg::LONG_IT);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == wrsi_pkg::CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // quotient is known to fit the iteration count, so the top bits start the remainder
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvs_q <= req_i.divisor;
      if (req_i.short_op) begin
        rem_q <= wrsi_pkg::DVS_W'(req_i.dividend >> wrsi_pkg::SHORT_IT);
        quo_q <= req_i.dividend << (wrsi_pkg::DVD_W - wrsi_pkg::SHORT_IT);
      end else begin
        rem_q <= wrsi_pkg::DVS_W'(req_i.dividend >> wrsi_pkg::LONG_IT);
        quo_q <= req_i.dividend << (wrsi_pkg::DVD_W - wrsi_pkg::LONG_IT);
      end
    end else if (busy_q) begin
      rem_q <= fits ? diff[wrsi_pkg::DVS_W-1:0] : trial[wrsi_pkg::DVS_W-1:0];
      quo_q <= {quo_q[wrsi_pkg::DVD_W-2:0], fits};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule
`default_nettype wire

[design/wrsi_regs.sv]
`default_nettype none
module wrsi_regs (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              psel_i,
  input  wire                              penable_i,
  input  wire                              pwrite_i,
  input  wire  [wrsi_pkg::ADDR_W-1:0]      paddr_i,
  input  wire  [wrsi_pkg::DATA_W-1:0]      pwdata_i,
  output logic [wrsi_pkg::DATA_W-1:0]      prdata_o,
  output logic                             pready_o,
  output logic [wrsi_pkg::PER_BITS-1:0]    period_o
);

  logic [wrsi_pkg::PER_BITS-1:0] period_q;
  wrsi_pkg::reg_idx_e            idx;
  logic                          wr_en;

  assign idx      = wrsi_pkg::reg_idx_e'(paddr_i[wrsi_pkg::ADDR_W-1:2]);
  assign wr_en    = psel_i & penable_i & pwrite_i;
  assign pready_o = 1'b1;
  assign period_o = period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= wrsi_pkg::PERIOD_RESET;
    end else if (wr_en && idx == wrsi_pkg::REG_PERIOD) begin
      period_q <= pwdata_i[wrsi_pkg::PER_BITS-1:0];
    end
  end

  always_comb begin
    unique case (idx)
      wrsi_pkg::REG_PERIOD: prdata_o = wrsi_pkg::DATA_W'(period_q);
      default:              prdata_o = '0;
    endcase
  end

endmodule
`default_nettype wire

[design/wrsi_seq.sv]
`default_nettype none
module wrsi_seq (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire  [wrsi_pkg::PER_BITS-1:0]     period_i,
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire  [wrsi_pkg::PRICE_BITS-1:0]   close_price_i,
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output logic [wrsi_pkg::RSI_BITS-1:0]     rsi_value_o,
  output wrsi_pkg::div_req_t                div_req_o,
  input  wrsi_pkg::div_rsp_t                div_rsp_i
);

  localparam int unsigned PB = wrsi_pkg::PRICE_BITS;
  localparam int unsigned AB = wrsi_pkg::AVG_BITS;

  wrsi_pkg::state_e state_q, state_d;

  logic [PB-1:0]                       price_q, price_d;
  logic [PB-1:0]                       last_q, last_d;
  logic [PB-1:0]                       move_q, move_d;
  logic                                up_q, up_d;
  logic [wrsi_pkg::PER_BITS-1:0]       warm_q, warm_d;
  logic [AB-1:0]                       avg_gain_q, avg_gain_d;
  logic [AB-1:0]                       avg_loss_q, avg_loss_d;
  logic                                seeded_q, seeded_d;
  logic [wrsi_pkg::RSI_BITS-1:0]       rsi_q, rsi_d;
  logic                                out_valid_q, out_valid_d;
  logic [wrsi_pkg::RSI_BITS-1:0]       out_rsi_q, out_rsi_d;

  logic [wrsi_pkg::PER_BITS-1:0]       p;
  logic [wrsi_pkg::PER_BITS-1:0]       pm1;
  logic [wrsi_pkg::PER_BITS-1:0]       warm_inc;
  logic [PB:0]                         diff;
  logic [PB-1:0]                       ndiff;
  logic [PB-1:0]                       gain_now;
  logic [PB-1:0]                       loss_now;
  logic                                use_loss;
  logic [AB-1:0]                       cur_avg;
  logic [PB-1:0]                       cur_move;
  logic [wrsi_pkg::PROD_W-1:0]         prod;
  logic [wrsi_pkg::DVD_W-1:0]          smooth_dvd;
  logic [wrsi_pkg::DVD_W-1:0]          seed_dvd;
  logic [wrsi_pkg::LONG_IT-1:0]        qlong;
  logic [AB-1:0]                       new_avg;

  assign p        = (period_i < wrsi_pkg::PERIOD_MIN) ? wrsi_pkg::PERIOD_MIN : period_i;
  assign pm1      = p - 1'b1;
  assign warm_inc = (warm_q != wrsi_pkg::WARM_MAX) ? warm_q + 1'b1 : warm_q;

  assign diff     = {1'b0, price_q} - {1'b0, last_q};
  assign ndiff    = last_q - price_q;
  assign gain_now = diff[PB] ? '0 : diff[PB-1:0];
  assign loss_now = diff[PB] ? ndiff : '0;

  assign use_loss   = (state_q == wrsi_pkg::S_LOSS);
  assign cur_avg    = use_loss ? avg_loss_q : avg_gain_q;
  assign cur_move   = use_loss ? (up_q ? '0 : move_q) : (up_q ? move_q : '0);
  assign prod       = wrsi_pkg::PROD_W'(cur_avg) * wrsi_pkg::PROD_W'(pm1);
  assign smooth_dvd = wrsi_pkg::DVD_W'(prod)
                    + wrsi_pkg::DVD_W'({cur_move, {wrsi_pkg::FRAC_BITS{1'b0}}});
  assign seed_dvd   = wrsi_pkg::DVD_W'({cur_avg, {wrsi_pkg::FRAC_BITS{1'b0}}});

  // seed saturates, smoothed average wraps to its width
  assign qlong   = div_rsp_i.quot[wrsi_pkg::LONG_IT-1:0];
  assign new_avg = (!seeded_q && (|qlong[wrsi_pkg::LONG_IT-1:AB])) ? '1 : qlong[AB-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wrsi_pkg::S_IDLE;
      last_q      <= '0;
      warm_q      <= '0;
      avg_gain_q  <= '0;
      avg_loss_q  <= '0;
      seeded_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      warm_q      <= warm_d;
      avg_gain_q  <= avg_gain_d;
      avg_loss_q  <= avg_loss_d;
      seeded_q    <= seeded_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    price_q   <= price_d;
    move_q    <= move_d;
    up_q      <= up_d;
    rsi_q     <= rsi_d;
    out_rsi_q <= out_rsi_d;
  end

  always_comb begin
    state_d     = state_q;
    price_d     = price_q;
    last_d      = last_q;
    move_d      = move_q;
    up_d        = up_q;
    warm_d      = warm_q;
    avg_gain_d  = avg_gain_q;
    avg_loss_d  = avg_loss_q;
    seeded_d    = seeded_q;
    rsi_d       = rsi_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_rsi_d   = out_rsi_q;
    in_ready_o  = 1'b0;
    div_req_o.start    = 1'b0;
    div_req_o.short_op = 1'b0;
    div_req_o.dividend = seeded_q ? smooth_dvd : seed_dvd;
    div_req_o.divisor  = wrsi_pkg::DVS_W'(p);

    unique case (state_q)
      wrsi_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          price_d = close_price_i;
          state_d = wrsi_pkg::S_MOVE;
        end
      end
      wrsi_pkg::S_MOVE: begin
        last_d = price_q;
        move_d = diff[PB] ? ndiff : diff[PB-1:0];
        up_d   = !diff[PB];
        if (seeded_q) begin
          state_d = wrsi_pkg::S_GAIN;
        end else if (warm_q == '0) begin
          warm_d  = wrsi_pkg::PER_BITS'(1);
          state_d = wrsi_pkg::S_IDLE;
        end else begin
          avg_gain_d = avg_gain_q + AB'(gain_now);
          avg_loss_d = avg_loss_q + AB'(loss_now);
          warm_d     = warm_inc;
          state_d    = (warm_inc < p) ? wrsi_pkg::S_IDLE : wrsi_pkg::S_GAIN;
        end
      end
      wrsi_pkg::S_GAIN: begin
        div_req_o.start = 1'b1;
        state_d         = wrsi_pkg::S_GAIN_WAIT;
      end
      wrsi_pkg::S_GAIN_WAIT: begin
        if (div_rsp_i.done) begin
          avg_gain_d = new_avg;
          state_d    = wrsi_pkg::S_LOSS;
        end
      end
      wrsi_pkg::S_LOSS: begin
        div_req_o.start = 1'b1;
        state_d         = wrsi_pkg::S_LOSS_WAIT;
      end
      wrsi_pkg::S_LOSS_WAIT: begin
        if (div_rsp_i.done) begin
          avg_loss_d = new_avg;
          seeded_d   = 1'b1;
          state_d    = wrsi_pkg::S_RSI;
        end
      end
      wrsi_pkg::S_RSI: begin
        div_req_o.short_op = 1'b1;
        div_req_o.dividend = wrsi_pkg::rsi_dividend(avg_gain_q);
        div_req_o.divisor  = wrsi_pkg::DVS_W'(avg_gain_q) + wrsi_pkg::DVS_W'(avg_loss_q);
        if (avg_loss_q == '0) begin
          rsi_d   = '0;
          state_d = wrsi_pkg::S_EMIT;
        end else begin
          div_req_o.start = 1'b1;
          state_d         = wrsi_pkg::S_RSI_WAIT;
        end
      end
      wrsi_pkg::S_RSI_WAIT: begin
        if (div_rsp_i.done) begin
          rsi_d   = div_rsp_i.quot[wrsi_pkg::RSI_BITS-1:0];
          state_d = wrsi_pkg::S_EMIT;
        end
      end
      wrsi_pkg::S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_rsi_d   = rsi_q;
          state_d     = wrsi_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = wrsi_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign rsi_value_o = out_rsi_q;

endmodule
`default_nettype wire

[design/wilder_rsi_indicator_top.sv]
// warm-up samples that give no result go back to idle from the move step; a seeding
// or smoothing sample offers its result after the gain, loss and (unless the average
// loss is zero) RSI divisions on the shared radix-2 divider: 57 + 57 + 15 iterations
// one sample is in work at a time; the output register frees the input side
// rst_ni clears all averages, counts and the previous close; period resets to 14
`default_nettype none
module wilder_rsi_indicator_top (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [wrsi_pkg::ADDR_W-1:0]       paddr,
  input  wire  [wrsi_pkg::DATA_W-1:0]       pwdata,
  output logic [wrsi_pkg::DATA_W-1:0]       prdata,
  output logic                              pready,
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire  [wrsi_pkg::PRICE_BITS-1:0]   close_price_i,
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output logic [wrsi_pkg::RSI_BITS-1:0]     rsi_value_o
);

  logic [wrsi_pkg::PER_BITS-1:0] period;
  wrsi_pkg::div_req_t            div_req;
  wrsi_pkg::div_rsp_t            div_rsp;

  wrsi_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .period_o  (period)
  );

  wrsi_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  wrsi_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .period_i      (period),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .close_price_i (close_price_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .rsi_value_o   (rsi_value_o),
    .div_req_o     (div_req),
    .div_rsp_i     (div_rsp)
  );

endmodule
`default_nettype wire
